### sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while in reset
`define A2B_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a2b assertion failed");

// next-cycle implication, held off while in reset
`define A2B_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a2b assertion failed");

`endif

### sv/a2b_pkg.sv
`default_nettype none
package a2b_pkg;

    // width of the accumulated nal length
    localparam int LEN_W = 32;

    // unit status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CUT   = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // start code bytes, last one is distinct
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;
    localparam logic [1:0] SC_LAST = 2'd3;

    // one step's worth of results
    typedef struct packed {
        logic       start;      // four-beat start code instead of a single beat
        logic [7:0] data_byte;
        logic       data_valid;
        logic       unit_done;
        logic [1:0] status;
        logic [7:0] profile;
        logic [7:0] level;
    } a2b_desc_t;

endpackage
`default_nettype wire

### sv/a2b_parse.sv
`default_nettype none
module a2b_parse
    import a2b_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic       mode,
    input  wire logic [7:0] in_byte,
    input  wire logic       last_byte,
    output logic            push,
    output a2b_desc_t       desc
);

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_HDR0    = 4'd1;
    localparam logic [3:0] PH_HDR1    = 4'd2;
    localparam logic [3:0] PH_HDR2    = 4'd3;
    localparam logic [3:0] PH_HDR3    = 4'd4;
    localparam logic [3:0] PH_HDR4    = 4'd5;
    localparam logic [3:0] PH_HDR5    = 4'd6;
    localparam logic [3:0] PH_SPS_LEN = 4'd7;
    localparam logic [3:0] PH_SPS_PAY = 4'd8;
    localparam logic [3:0] PH_PPS_CNT = 4'd9;
    localparam logic [3:0] PH_PPS_LEN = 4'd10;
    localparam logic [3:0] PH_PPS_PAY = 4'd11;
    localparam logic [3:0] PH_FRM_LEN = 4'd12;
    localparam logic [3:0] PH_FRM_PAY = 4'd13;
    localparam logic [3:0] PH_TAIL    = 4'd14;

    typedef struct packed {
        logic [3:0]       phase;
        logic [LEN_W-1:0] acc;
        logic [2:0]       seen;
        logic [LEN_W-1:0] left;
        logic [1:0]       lsm1;
        logic [4:0]       sps;
        logic [7:0]       pps;
        logic [7:0]       prof;
        logic [7:0]       lvl;
    } a2b_state_t;

    a2b_state_t st_reg;
    a2b_state_t st_next;

    // end of one nal: move to the next one or on to the next section
    function automatic a2b_state_t nal_done(input a2b_state_t s_in);
        a2b_state_t s;
        s      = s_in;
        s.acc  = '0;
        s.seen = '0;
        s.left = '0;
        if (s.phase == PH_SPS_LEN || s.phase == PH_SPS_PAY)
        begin
            s.sps   = s.sps - 5'd1;
            s.phase = (s.sps != '0) ? PH_SPS_LEN : PH_PPS_CNT;
        end
        else if (s.phase == PH_PPS_LEN || s.phase == PH_PPS_PAY)
        begin
            s.pps   = s.pps - 8'd1;
            s.phase = (s.pps != '0) ? PH_PPS_LEN : PH_TAIL;
        end
        else
        begin
            s.phase = PH_FRM_LEN;
        end
        return s;
    endfunction

    always_comb
    begin
        a2b_state_t s;
        a2b_desc_t  d;
        logic       has;
        logic [2:0] size;
        s    = st_reg;
        d    = '0;
        has  = 1'b0;
        size = 3'd2;
        if (accept)
        begin
            if (s.phase == PH_START)
            begin
                s.phase = mode ? PH_HDR0 : PH_FRM_LEN;
                s.acc   = '0;
                s.seen  = '0;
                s.left  = '0;
            end
            case (s.phase)
                PH_HDR0: s.phase = PH_HDR1;
                PH_HDR1:
                begin
                    s.prof  = in_byte;
                    s.phase = PH_HDR2;
                end
                PH_HDR2: s.phase = PH_HDR3;
                PH_HDR3:
                begin
                    s.lvl   = in_byte;
                    s.phase = PH_HDR4;
                end
                PH_HDR4:
                begin
                    s.lsm1  = in_byte[1:0];
                    s.phase = PH_HDR5;
                end
                PH_HDR5:
                begin
                    s.sps   = in_byte[4:0];
                    s.acc   = '0;
                    s.seen  = '0;
                    s.phase = (s.sps != '0) ? PH_SPS_LEN : PH_PPS_CNT;
                end
                PH_PPS_CNT:
                begin
                    s.pps   = in_byte;
                    s.acc   = '0;
                    s.seen  = '0;
                    s.phase = (s.pps != '0) ? PH_PPS_LEN : PH_TAIL;
                end
                PH_SPS_LEN, PH_PPS_LEN, PH_FRM_LEN:
                begin
                    if (s.phase == PH_FRM_LEN)
                    begin
                        size = {1'b0, s.lsm1} + 3'd1;
                    end
                    s.acc  = {s.acc[LEN_W-9:0], in_byte};
                    s.seen = s.seen + 3'd1;
                    if (s.seen >= size)
                    begin
                        if (s.acc != '0 && last_byte)
                        begin
                            // length done but unit ends, no start code
                            s.phase = s.phase + 4'd1;
                        end
                        else
                        begin
                            has     = 1'b1;
                            d.start = 1'b1;
                            if (s.acc == '0)
                            begin
                                s = nal_done(s);
                            end
                            else
                            begin
                                s.left  = s.acc;
                                s.acc   = '0;
                                s.seen  = '0;
                                s.phase = s.phase + 4'd1;
                            end
                        end
                    end
                end
                PH_SPS_PAY, PH_PPS_PAY, PH_FRM_PAY:
                begin
                    has          = 1'b1;
                    d.data_byte  = in_byte;
                    d.data_valid = 1'b1;
                    if (s.left != '0)
                    begin
                        s.left = s.left - {{(LEN_W-1){1'b0}}, 1'b1};
                    end
                    if (s.left == '0)
                    begin
                        s = nal_done(s);
                    end
                end
                default: s.phase = PH_TAIL;
            endcase
            if (last_byte)
            begin
                has         = 1'b1;
                d.unit_done = 1'b1;
                if (s.phase inside {[PH_HDR0:PH_HDR5]})
                begin
                    d.status = ST_SHORT;
                end
                else if (s.phase inside {PH_SPS_PAY, PH_PPS_PAY, PH_FRM_PAY})
                begin
                    d.status = ST_CUT;
                end
                else if (s.phase inside {PH_SPS_LEN, PH_PPS_LEN, PH_FRM_LEN} &&
                         s.seen != '0)
                begin
                    d.status = ST_CUT;
                end
                else
                begin
                    d.status = ST_OK;
                end
                s.phase = PH_START;
                s.acc   = '0;
                s.seen  = '0;
                s.left  = '0;
            end
        end
        d.profile = s.prof;
        d.level   = s.lvl;
        st_next   = s;
        push      = has;
        desc      = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: PH_START, acc: '0, seen: '0, left: '0, lsm1: 2'd3,
                        sps: '0, pps: '0, prof: '0, lvl: '0};
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule
`default_nettype wire

### sv/a2b_emit.sv
`default_nettype none
module a2b_emit
    import a2b_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire a2b_desc_t  desc,
    output logic            space,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            run_last,
    output logic            unit_done,
    output logic [1:0]      status,
    output logic [7:0]      profile,
    output logic [7:0]      level
);

    a2b_desc_t  mem [2];
    logic       head_reg;
    logic       tail_reg;
    logic [1:0] count_reg;
    logic [1:0] idx_reg;

    a2b_desc_t  hd;
    logic       beat;
    logic       pop;

    assign hd        = mem[head_reg];
    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign run_last  = !hd.start || (idx_reg == SC_LAST);
    assign beat      = out_valid && out_ready;
    assign pop       = beat && run_last;

    always_comb
    begin
        if (hd.start)
        begin
            out_byte   = (idx_reg == SC_LAST) ? SC_ONE : SC_ZERO;
            byte_valid = 1'b1;
        end
        else
        begin
            out_byte   = hd.data_byte;
            byte_valid = hd.data_valid;
        end
        unit_done = hd.unit_done && run_last;
        status    = run_last ? hd.status : ST_OK;
        profile   = hd.profile;
        level     = hd.level;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= !tail_reg;
            end
            if (pop)
            begin
                head_reg <= !head_reg;
                idx_reg  <= 2'd0;
            end
            else if (beat)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

### sv/avcc_to_annexb_converter.sv
// the results of a byte are registered in the result queue and offered from its head
// throughput: one input byte per cycle while the result queue has a free slot; a byte
// that completes a nal length gives a start code (00 00 00 01) as output beats
// a two-entry result queue parts input ready from output ready
// reset (rst_n low, asynchronous) returns the parser to unit start with
// four-byte lengths, clears profile and level and empties the result queue
`default_nettype none
module avcc_to_annexb_converter
    import a2b_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       mode,
    input  wire logic [7:0] in_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            run_last,
    output logic            unit_done,
    output logic [1:0]      status,
    output logic [7:0]      profile,
    output logic [7:0]      level
);

    // input beat taken whenever the result queue has a free slot
    logic      accept;
    logic      push;
    logic      space;
    a2b_desc_t desc;

    assign in_ready = space;
    assign accept   = in_valid && in_ready;

    // parser: phase tracking, length accumulation, record fields
    a2b_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (mode),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .push      (push),
        .desc      (desc)
    );

    // emitter: queues each byte's results and expands start codes into beats
    a2b_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .desc       (desc),
        .space      (space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .unit_done  (unit_done),
        .status     (status),
        .profile    (profile),
        .level      (level)
    );

endmodule
`default_nettype wire

### sv/a2b_checker.sv
`default_nettype none
`include "assert_macros.svh"
module a2b_checker
    import a2b_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       mode,
    input wire logic [7:0] in_byte,
    input wire logic       last_byte,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       run_last,
    input wire logic       unit_done,
    input wire logic [1:0] status
);

    // a waiting input beat keeps its payload
    `A2B_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable({mode, in_byte, last_byte}))
    // a stalled beat keeps its byte
    `A2B_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte))
    // unit close is always the final result of its byte
    `A2B_ASSERT_NOW(a_done_last, clk, rst_n, out_valid && unit_done, run_last)
    // a status-only result closes a unit and carries a zero byte
    `A2B_ASSERT_NOW(a_empty_done, clk, rst_n, out_valid && !byte_valid, unit_done && out_byte == 8'h00)
    // non-ok status only on the closing result, never an unused code
    `A2B_ASSERT_NOW(a_status_ok, clk, rst_n, out_valid && status != ST_OK, unit_done && status <= ST_SHORT)

endmodule

bind avcc_to_annexb_converter a2b_checker u_a2b_checker (.*);
`default_nettype wire
